// ===== rtl/mec_pkg.sv =====
// Package for the Mandelbrot escape counter: widths, reset values, register
// indexes and the shared structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mec_pkg;

  localparam int LIMIT_W   = 16;
  localparam int CFG_W     = 32;
  localparam int IDX_W     = 3;
  localparam int DIM_W     = 12;
  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 28;

  localparam int MW  = 32;
  localparam int PW  = 2 * MW;
  localparam int CW  = CFG_W + DIM_W + 1;
  localparam int XW  = FRAC_BITS + 2;
  localparam int SQW = FRAC_BITS + 2;
  localparam int XYW = FRAC_BITS + 4;
  localparam int NW  = CW + 1;

  localparam logic [IDX_W-1:0] REG_LIMIT       = 3'd0;
  localparam logic [IDX_W-1:0] REG_REAL_ORIGIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_IMAG_ORIGIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_REAL_STEP   = 3'd3;
  localparam logic [IDX_W-1:0] REG_IMAG_STEP   = 3'd4;

  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 16'd10000;
  localparam logic [CFG_W-1:0]   ORIGIN_RST = 32'hE000_0000;
  localparam logic [CFG_W-1:0]   STEP_RST   = 32'd1342177;

  typedef struct packed {
    logic [LIMIT_W-1:0] iteration_limit;
    logic [CFG_W-1:0]   real_origin;
    logic [CFG_W-1:0]   imag_origin;
    logic [CFG_W-1:0]   real_step;
    logic [CFG_W-1:0]   imag_step;
  } mec_cfg_t;

  typedef struct packed {
    logic          en;
    logic [MW-1:0] a0;
    logic [MW-1:0] b0;
    logic [MW-1:0] a1;
    logic [MW-1:0] b1;
    logic [MW-1:0] a2;
    logic [MW-1:0] b2;
  } mec_mul_cmd_t;

  typedef struct packed {
    logic [PW-1:0] p0;
    logic [PW-1:0] p1;
    logic [PW-1:0] p2;
  } mec_mul_res_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (32'(v) >= MAX_DIM) begin
      return DIM_W'(MAX_DIM - 1);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mec_cfg_regs.sv =====
// Configuration register file of the Mandelbrot escape counter.
// Depends on mec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mec_cfg_regs (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire [mec_pkg::IDX_W-1:0]    cfg_index,
  input  wire [mec_pkg::CFG_W-1:0]    cfg_wdata,
  output mec_pkg::mec_cfg_t           cfg
);
  import mec_pkg::*;

  mec_cfg_t cfg_r;
  mec_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_LIMIT:       cfg_nxt.iteration_limit = cfg_wdata[LIMIT_W-1:0];
        REG_REAL_ORIGIN: cfg_nxt.real_origin = cfg_wdata;
        REG_IMAG_ORIGIN: cfg_nxt.imag_origin = cfg_wdata;
        REG_REAL_STEP:   cfg_nxt.real_step = cfg_wdata;
        REG_IMAG_STEP:   cfg_nxt.imag_step = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.iteration_limit <= LIMIT_RST;
      cfg_r.real_origin     <= ORIGIN_RST;
      cfg_r.imag_origin     <= ORIGIN_RST;
      cfg_r.real_step       <= STEP_RST;
      cfg_r.imag_step       <= STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/mec_mul_unit.sv =====
// Shared multiplier unit: three signed 32 x 32 multipliers with registered
// full-width products, loaded on command. Depends on mec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mec_mul_unit (
  input  wire                     clk,
  input  mec_pkg::mec_mul_cmd_t   cmd,
  output mec_pkg::mec_mul_res_t   res
);
  import mec_pkg::*;

  logic signed [MW-1:0] a0_s, b0_s, a1_s, b1_s, a2_s, b2_s;
  logic signed [PW-1:0] p0_r, p1_r, p2_r;

  assign a0_s = cmd.a0;
  assign b0_s = cmd.b0;
  assign a1_s = cmd.a1;
  assign b1_s = cmd.b1;
  assign a2_s = cmd.a2;
  assign b2_s = cmd.b2;

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      p0_r <= a0_s * b0_s;
      p1_r <= a1_s * b1_s;
      p2_r <= a2_s * b2_s;
    end
  end

  assign res.p0 = p0_r;
  assign res.p1 = p1_r;
  assign res.p2 = p2_r;

endmodule

`default_nettype wire

// ===== rtl/mec_seq.sv =====
// Sequencer and fixed-point datapath of the escape-time iteration.
// Drives the shared multiplier unit. Depends on mec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mec_seq (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  input  wire [mec_pkg::DIM_W-1:0]    in_column,
  input  wire [mec_pkg::DIM_W-1:0]    in_row,
  input  mec_pkg::mec_cfg_t           cfg,
  input  mec_pkg::mec_mul_res_t       mres,
  output mec_pkg::mec_mul_cmd_t       mcmd,
  output logic                        busy,
  output logic                        out_valid,
  output logic [mec_pkg::LIMIT_W-1:0] out_escape_count
);
  import mec_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMUL = 3'd1;
  localparam logic [2:0] S_CADD = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;

  localparam logic signed [NW-1:0] TWO_N   = NW'(2) << FRAC_BITS;
  localparam logic [SQW:0]         FOUR_SQ = (SQW + 1)'(4) << FRAC_BITS;

  logic [2:0]               state_r, state_nxt;
  logic [DIM_W-1:0]         col_r, col_nxt, row_r, row_nxt;
  logic                     first_r, first_nxt;
  logic [LIMIT_W-1:0]       cnt_r, cnt_nxt, cnt_inc;
  logic signed [CW-1:0]     cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [XW-1:0]     x_r, x_nxt, y_r, y_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [LIMIT_W-1:0]       out_cnt_r, out_cnt_nxt;

  logic signed [PW-1:0]     p0_sh, p1_sh, p2_sh;
  logic [SQW-1:0]           xx, yy;
  logic signed [XYW-1:0]    xy2;
  logic signed [SQW:0]      xx_s, yy_s;
  logic [SQW:0]             sq_sum;
  logic                     sq_esc;
  logic signed [NW-1:0]     x_new, y_new;
  logic                     out_rng;
  logic signed [CW-1:0]     cx_sum, cy_sum;

  assign p0_sh = $signed(mres.p0) >>> FRAC_BITS;
  assign p1_sh = $signed(mres.p1) >>> FRAC_BITS;
  assign p2_sh = $signed(mres.p2) >>> (FRAC_BITS - 1);

  assign xx  = first_r ? '0 : p0_sh[SQW-1:0];
  assign yy  = first_r ? '0 : p1_sh[SQW-1:0];
  assign xy2 = first_r ? '0 : p2_sh[XYW-1:0];

  assign xx_s   = $signed({1'b0, xx});
  assign yy_s   = $signed({1'b0, yy});
  assign sq_sum = {1'b0, xx} + {1'b0, yy};
  assign sq_esc = (sq_sum >= FOUR_SQ);

  assign x_new = NW'(cx_r) + NW'(xx_s) - NW'(yy_s);
  assign y_new = NW'(cy_r) + NW'(xy2);
  assign out_rng = (x_new >= TWO_N) || (x_new <= -TWO_N) ||
                   (y_new >= TWO_N) || (y_new <= -TWO_N);

  assign cnt_inc = cnt_r + LIMIT_W'(1);

  assign cx_sum = CW'($signed(cfg.real_origin)) + $signed(mres.p0[CW-1:0]);
  assign cy_sum = CW'($signed(cfg.imag_origin)) + $signed(mres.p1[CW-1:0]);

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    first_nxt     = first_r;
    cnt_nxt       = cnt_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    out_valid_nxt = 1'b0;
    out_cnt_nxt   = out_cnt_r;
    mcmd          = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          col_nxt   = clamp_dim(in_column);
          row_nxt   = clamp_dim(in_row);
          state_nxt = S_CMUL;
        end
      end
      S_CMUL: begin
        mcmd.en   = 1'b1;
        mcmd.a0   = MW'(col_r);
        mcmd.b0   = cfg.real_step;
        mcmd.a1   = MW'(row_r);
        mcmd.b1   = cfg.imag_step;
        state_nxt = S_CADD;
      end
      S_CADD: begin
        cx_nxt    = cx_sum;
        cy_nxt    = cy_sum;
        first_nxt = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (sq_esc || (cnt_r == cfg.iteration_limit)) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = cnt_r;
          state_nxt     = S_IDLE;
        end else if (out_rng) begin
          out_valid_nxt = 1'b1;
          out_cnt_nxt   = cnt_inc;
          state_nxt     = S_IDLE;
        end else begin
          x_nxt     = x_new[XW-1:0];
          y_nxt     = y_new[XW-1:0];
          cnt_nxt   = cnt_inc;
          first_nxt = 1'b0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        mcmd.en   = 1'b1;
        mcmd.a0   = MW'(x_r);
        mcmd.b0   = MW'(x_r);
        mcmd.a1   = MW'(y_r);
        mcmd.b1   = MW'(y_r);
        mcmd.a2   = MW'(x_r);
        mcmd.b2   = MW'(y_r);
        state_nxt = S_UPD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r     <= col_nxt;
    row_r     <= row_nxt;
    first_r   <= first_nxt;
    cnt_r     <= cnt_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_escape_count = out_cnt_r;

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_escape_counter_core.sv =====
// From the start transfer to the out_valid strobe, the sequencer computes the point
// c, then passes through a multiply state and an update state per iteration of the loop
// on the shared three-multiplier unit.
// Throughput: one pixel at a time; a new start is taken in the strobe cycle.
// The strobe lasts one cycle and cannot be stalled. Synchronous active-low reset
// returns the sequencer to idle and loads the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_counter_core (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire [mec_pkg::DIM_W-1:0]    in_column,
  input  wire [mec_pkg::DIM_W-1:0]    in_row,
  output logic                        out_valid,
  output logic [mec_pkg::LIMIT_W-1:0] out_escape_count,
  input  wire                         cfg_we,
  input  wire [mec_pkg::IDX_W-1:0]    cfg_index,
  input  wire [mec_pkg::CFG_W-1:0]    cfg_wdata
);
  import mec_pkg::*;

  mec_cfg_t     cfg;
  mec_mul_cmd_t mcmd;
  mec_mul_res_t mres;

  mec_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mec_mul_unit u_mul (
    .clk (clk),
    .cmd (mcmd),
    .res (mres)
  );

  mec_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_column        (in_column),
    .in_row           (in_row),
    .cfg              (cfg),
    .mres             (mres),
    .mcmd             (mcmd),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_escape_count (out_escape_count)
  );

endmodule

`default_nettype wire

// ===== rtl/mec_checker.sv =====
// Port-level checker for the Mandelbrot escape counter and its bind to the
// top level. Depends on mandelbrot_escape_counter_core.
`timescale 1ns / 1ps
`default_nettype none

module mec_checker (
  input wire clk,
  input wire rst_n,
  input wire start,
  input wire busy,
  input wire out_valid
);

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding work");

endmodule

bind mandelbrot_escape_counter_core mec_checker u_mec_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for mandelbrot_escape_counter_core: a directed table and random
// views of the set, with an escape-count predictor and an in-order result check.
// Depends on rtl/mec_pkg.sv and rtl/mandelbrot_escape_counter_core.sv.
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import mec_pkg::*;

  localparam int PLAN_LEN       = 42;
  localparam int RAND_PHASES    = 5;
  localparam int PIXELS_PER_VIEW = 20;
  localparam int MAX_REPORTS    = 10;
  localparam int WATCHDOG_LIMIT = 600000;

  typedef enum logic {PLAN_ITEM, PLAN_CFG} plan_kind_t;

  typedef struct packed {
    plan_kind_t         kind;
    logic [IDX_W-1:0]   idx;
    logic [CFG_W-1:0]   data;
    logic [DIM_W-1:0]   col;
    logic [DIM_W-1:0]   row;
    logic               typed;
    logic [LIMIT_W-1:0] want;
  } plan_t;

  typedef struct packed {
    logic [DIM_W-1:0]   col;
    logic [DIM_W-1:0]   row;
    logic [LIMIT_W-1:0] count;
  } pixel_count_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [DIM_W-1:0]    in_column = '0;
  logic [DIM_W-1:0]    in_row = '0;
  logic                out_valid;
  logic [LIMIT_W-1:0]  out_escape_count;
  logic                cfg_we = 1'b0;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  logic [LIMIT_W-1:0]  lim_q;
  int                  re_org;
  int                  im_org;
  int                  re_stp;
  int                  im_stp;

  pixel_count_t        awaited_counts[$];
  plan_t               plan [PLAN_LEN];
  int                  errors = 0;
  int                  reports = 0;
  int                  counts_checked = 0;
  int                  pixels_sent = 0;
  int                  reg_writes = 0;
  int                  idle_cycles = 0;
  bit                  no_gaps = 1'b0;

  mandelbrot_escape_counter_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_column        (in_column),
    .in_row           (in_row),
    .out_valid        (out_valid),
    .out_escape_count (out_escape_count),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic longint scaled_product(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic logic [LIMIT_W-1:0] escape_iterations(logic [DIM_W-1:0] col,
                                                          logic [DIM_W-1:0] row);
    longint cx;
    longint cy;
    longint x;
    longint y;
    longint xx;
    longint yy;
    longint xy2;
    longint two_q;
    longint four_q;
    int     n;
    bit     gone;
    two_q  = longint'(2) << FRAC_BITS;
    four_q = longint'(4) << FRAC_BITS;
    cx = longint'(re_org) + longint'(col) * longint'(re_stp);
    cy = longint'(im_org) + longint'(row) * longint'(im_stp);
    x = 0;
    y = 0;
    n = 0;
    gone = 1'b0;
    while (n < int'(lim_q) && !gone) begin
      xx  = scaled_product(x, x);
      yy  = scaled_product(y, y);
      xy2 = scaled_product(2 * x, y);
      x = xx - yy + cx;
      y = xy2 + cy;
      n++;
      if (x >= two_q || x <= -two_q || y >= two_q || y <= -two_q) begin
        gone = 1'b1;
      end else begin
        gone = (scaled_product(x, x) + scaled_product(y, y)) >= four_q;
      end
    end
    return n[LIMIT_W-1:0];
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    if (start) begin
      @(negedge clk);
      start <= 1'b0;
    end
    while (awaited_counts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_LIMIT:       lim_q  = data[LIMIT_W-1:0];
      REG_REAL_ORIGIN: re_org = signed'(data);
      REG_IMAG_ORIGIN: im_org = signed'(data);
      REG_REAL_STEP:   re_stp = signed'(data);
      REG_IMAG_STEP:   im_stp = signed'(data);
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_pixel(logic [DIM_W-1:0] col, logic [DIM_W-1:0] row, bit typed,
                            logic [LIMIT_W-1:0] want);
    int           gap;
    pixel_count_t entry;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start     <= 1'b1;
    in_column <= col;
    in_row    <= row;
    do @(posedge clk); while (busy);
    entry.col   = col;
    entry.row   = row;
    entry.count = typed ? want : escape_iterations(col, row);
    awaited_counts.push_back(entry);
    pixels_sent++;
  endtask

  always @(posedge clk) begin
    pixel_count_t exp_entry;
    if (rst_n && out_valid) begin
      if (awaited_counts.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          $display("Unexpected result: count %0d with no transfer pending",
                   out_escape_count);
          reports++;
        end
      end else begin
        exp_entry = awaited_counts.pop_front();
        counts_checked++;
        if (out_escape_count !== exp_entry.count) begin
          errors++;
          if (reports < MAX_REPORTS) begin
            $display("Mismatch for pixel (%0d, %0d): expected count %0d, got %0d",
                     exp_entry.col, exp_entry.row, exp_entry.count, out_escape_count);
            reports++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transfer", idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    lim_q  = LIMIT_RST;
    re_org = signed'(ORIGIN_RST);
    im_org = signed'(ORIGIN_RST);
    re_stp = signed'(STEP_RST);
    im_stp = signed'(STEP_RST);
    plan = '{
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd0, 12'd0, 1'b1, 16'd1},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd4095, 12'd4095, 1'b1, 16'd1},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd4095, 12'd0, 1'b1, 16'd1},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd0, 12'd4095, 1'b1, 16'd1},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd400, 12'd400, 1'b1, 16'd10000},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd200, 12'd400, 1'b0, 16'd0},
      '{PLAN_CFG, REG_LIMIT, 32'd0, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd1234, 12'd567, 1'b1, 16'd0},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd4095, 12'd4095, 1'b1, 16'd0},
      '{PLAN_CFG, REG_LIMIT, 32'd1, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd400, 12'd400, 1'b1, 16'd1},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd2048, 12'd1024, 1'b1, 16'd1},
      '{PLAN_CFG, REG_LIMIT, 32'd65535, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_CFG, REG_REAL_ORIGIN, 32'd0, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_CFG, REG_IMAG_ORIGIN, 32'd0, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_CFG, REG_REAL_STEP, 32'd0, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_CFG, REG_IMAG_STEP, 32'd0, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd4095, 12'd4095, 1'b1, 16'd65535},
      '{PLAN_CFG, REG_REAL_ORIGIN, 32'h1800_0000, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_CFG, REG_IMAG_ORIGIN, 32'h1800_0000, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd77, 12'd3000, 1'b1, 16'd1},
      '{PLAN_CFG, REG_REAL_ORIGIN, 32'h7FFF_FFFF, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_CFG, REG_IMAG_ORIGIN, 32'h8000_0000, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_CFG, REG_REAL_STEP, 32'h7FFF_FFFF, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_CFG, REG_IMAG_STEP, 32'h8000_0000, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd0, 12'd0, 1'b1, 16'd1},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd4095, 12'd4095, 1'b1, 16'd1},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd4095, 12'd0, 1'b1, 16'd1},
      '{PLAN_CFG, REG_REAL_STEP, 32'h8000_0000, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_CFG, REG_IMAG_STEP, 32'h7FFF_FFFF, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd4095, 12'd4095, 1'b1, 16'd1},
      '{PLAN_CFG, REG_LIMIT, 32'd500, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_CFG, REG_REAL_ORIGIN, 32'hE000_0000, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_CFG, REG_IMAG_ORIGIN, 32'hEC00_0000, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_CFG, REG_REAL_STEP, 32'h0003_0000, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_CFG, REG_IMAG_STEP, 32'h0002_8000, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_CFG, REG_IMAG_STEP + 3'd1, 32'h7FFF_FFFF, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_CFG, REG_IMAG_STEP + 3'd2, 32'h8000_0000, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_CFG, REG_IMAG_STEP + 3'd3, 32'hFFFF_FFFF, 12'd0, 12'd0, 1'b0, 16'd0},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd2730, 12'd2048, 1'b0, 16'd0},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd1365, 12'd1024, 1'b0, 16'd0},
      '{PLAN_ITEM, REG_LIMIT, 32'd0, 12'd0, 12'd2048, 1'b0, 16'd0}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == PLAN_CFG) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_pixel(plan[i].col, plan[i].row, plan[i].typed, plan[i].want);
      end
    end

    // The last view puts raw values in origins and steps; the others frame the set.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      no_gaps = (ph % 2 == 1);
      if (ph == RAND_PHASES - 1) begin
        write_reg(REG_LIMIT, $urandom_range(0, 24));
        write_reg(REG_REAL_ORIGIN, $urandom());
        write_reg(REG_IMAG_ORIGIN, $urandom());
        write_reg(REG_REAL_STEP, $urandom());
        write_reg(REG_IMAG_STEP, $urandom());
      end else begin
        write_reg(REG_LIMIT, (ph == 0) ? $urandom_range(500, 2000) : $urandom_range(1, 400));
        write_reg(REG_REAL_ORIGIN, -$urandom_range(268435456, 671088640));
        write_reg(REG_IMAG_ORIGIN, -$urandom_range(67108864, 402653184));
        write_reg(REG_REAL_STEP, $urandom_range(20000, 200000));
        write_reg(REG_IMAG_STEP, $urandom_range(10000, 150000));
      end
      for (int k = 0; k < PIXELS_PER_VIEW; k++) begin
        send_pixel(DIM_W'($urandom_range(0, MAX_DIM - 1)),
                   DIM_W'($urandom_range(0, MAX_DIM - 1)), 1'b0, '0);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (awaited_counts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (awaited_counts.size() != 0) begin
      errors += awaited_counts.size();
    end
    $display("Run covered %0d pixels and %0d register writes; %0d escape counts checked.",
             pixels_sent, reg_writes, counts_checked);
    $display("Mismatches and stray results: %0d.", errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
